// ===== rtl/tlc_pkg.sv =====
// ----------------------------------------------------------------------------
// Three-level cache tag lookup package
// Shared types and codes for the tag lookup block and its submodules.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int TAG_W  = 32;
    localparam int ENT_W  = TAG_W + 1;
    localparam int CNT_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2   = 2'd1;

    localparam logic [3:0] BLOCK_SHIFT_RST = 4'd6;
    localparam logic [1:0] WAYS_LOG2_RST   = 2'd1;

    localparam logic [1:0] SRV_L1  = 2'd0;
    localparam logic [1:0] SRV_L2  = 2'd1;
    localparam logic [1:0] SRV_L3  = 2'd2;
    localparam logic [1:0] SRV_MEM = 2'd3;

    localparam int CNT_L1_HIT  = 0;
    localparam int CNT_L1_MISS = 1;
    localparam int CNT_L2_HIT  = 2;
    localparam int CNT_L2_MISS = 3;
    localparam int CNT_L3_HIT  = 4;
    localparam int CNT_L3_MISS = 5;
    localparam int NUM_CNT     = 6;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOOK,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic fill;
        logic clr;
    } t_lvl_ctl;

endpackage

// ===== rtl/tlc_if.sv =====
// ----------------------------------------------------------------------------
// Tag lookup channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tlc_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface tlc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  served_by;
    logic [31:0] first_hits;
    logic [31:0] first_misses;
    logic [31:0] second_hits;
    logic [31:0] second_misses;
    logic [31:0] third_hits;
    logic [31:0] third_misses;

    modport source (output valid, output served_by, output first_hits,
                    output first_misses, output second_hits, output second_misses,
                    output third_hits, output third_misses, input ready);
    modport sink   (input valid, input served_by, input first_hits,
                    input first_misses, input second_hits, input second_misses,
                    input third_hits, input third_misses, output ready);
endinterface

interface tlc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [3:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tlc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tlc_level.sv =====
// ----------------------------------------------------------------------------
// Tag store level
// One set per RAM row holding every way and the round-robin pointer.
// ----------------------------------------------------------------------------
module tlc_level #(
    parameter int LINES    = 16,
    parameter int MAX_WAYS = 8,
    parameter int CW       = 8
) (
    input  logic                  i_clk,
    input  tlc_pkg::t_lvl_ctl     i_ctl,
    input  logic [31:0]           i_blk,
    input  logic [1:0]            i_wl2,
    input  logic [CW-1:0]         i_clr_idx,
    output logic                  o_hit
);

    localparam int AW = $clog2(LINES);
    localparam int PW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int EW = tlc_pkg::ENT_W;
    localparam int RW = MAX_WAYS * EW + PW;

    logic [AW-1:0] set_idx;
    logic [RW-1:0] row;
    logic [RW-1:0] fill_row;
    logic [PW-1:0] way_mask;
    logic [PW-1:0] way_sel;
    logic [PW-1:0] ptr_next;
    logic          we;
    logic [AW-1:0] waddr;
    logic [RW-1:0] wdata;

    assign set_idx  = i_blk[AW-1:0] & ({AW{1'b1}} >> i_wl2);
    assign way_mask = ~({PW{1'b1}} << i_wl2);
    assign way_sel  = row[MAX_WAYS*EW +: PW] & way_mask;
    assign ptr_next = (way_sel + PW'(1)) & way_mask;

    always_comb begin
        o_hit = 1'b0;
        for (int k = 0; k < MAX_WAYS; k++) begin
            if (((k >> i_wl2) == 0) && row[k*EW + tlc_pkg::TAG_W]
                && (row[k*EW +: tlc_pkg::TAG_W] == i_blk)) begin
                o_hit = 1'b1;
            end
        end
    end

    always_comb begin
        fill_row = row;
        for (int k = 0; k < MAX_WAYS; k++) begin
            if (PW'(k) == way_sel) begin
                fill_row[k*EW +: EW] = {1'b1, i_blk};
            end
        end
        fill_row[MAX_WAYS*EW +: PW] = ptr_next;
    end

    assign we    = i_ctl.fill | i_ctl.clr;
    assign waddr = i_ctl.clr ? i_clr_idx[AW-1:0] : set_idx;
    assign wdata = i_ctl.clr ? '0 : fill_row;

    tlc_ram #(
        .WIDTH (RW),
        .DEPTH (LINES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (set_idx),
        .o_rdata (row)
    );

endmodule

// ===== rtl/three_level_cache_tag_lookup.sv =====
// ----------------------------------------------------------------------------
// Three-level cache tag lookup
// Looks an address up in three FIFO-replaced set-associative tag stores.
// ----------------------------------------------------------------------------
// A request is taken only in the idle state, one item at a time, and then
// goes through the read, compare and write-back of the tag RAM rows (one row
// per set holds all ways and the pointer); write-back waits for a free output.
// Reset, and every write to the ways register, starts a clearing pass over
// the rows of all three tag RAMs during which no request is taken.
module three_level_cache_tag_lookup #(
    parameter int L1_LINES = 16,
    parameter int L2_LINES = 64,
    parameter int L3_LINES = 256,
    parameter int MAX_WAYS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlc_req_if.sink    i_req,
    tlc_rsp_if.source  o_rsp,
    tlc_cfg_if.sink    i_cfg
);

    localparam int MAXD12 = (L1_LINES > L2_LINES) ? L1_LINES : L2_LINES;
    localparam int MAXD   = (MAXD12 > L3_LINES) ? MAXD12 : L3_LINES;
    localparam int CW     = $clog2(MAXD);
    localparam int MWL    = $clog2(MAX_WAYS);

    tlc_pkg::t_state r_state, n_state;

    logic [3:0]  r_block_shift;
    logic [1:0]  r_ways_log2;
    logic [CW-1:0] r_clr_cnt;
    logic [31:0] r_blk;
    logic [1:0]  r_served;
    logic [tlc_pkg::CNT_W-1:0] r_cnt [tlc_pkg::NUM_CNT];
    logic [tlc_pkg::CNT_W-1:0] n_cnt [tlc_pkg::NUM_CNT];
    logic        r_out_valid;
    logic [1:0]  r_out_served;
    logic [tlc_pkg::CNT_W-1:0] r_out_cnt [tlc_pkg::NUM_CNT];

    logic [1:0]  wl2_eff;
    logic        cfg_wr;
    logic        ways_wr;
    logic        req_xfer;
    logic        out_free;
    logic        advance;
    logic        hit1, hit2, hit3;
    logic        clearing;
    tlc_pkg::t_lvl_ctl ctl1, ctl2, ctl3;

    assign wl2_eff  = (r_ways_log2 > 2'(MWL)) ? 2'(MWL) : r_ways_log2;
    assign cfg_wr   = i_cfg.valid & i_cfg.ready;
    assign ways_wr  = cfg_wr && (i_cfg.index == tlc_pkg::CFG_WAYS_LOG2);
    assign req_xfer = i_req.valid & i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlc_pkg::ST_CLEAR: begin
                if (r_clr_cnt == CW'(MAXD - 1)) n_state = tlc_pkg::ST_IDLE;
            end
            tlc_pkg::ST_IDLE: begin
                if (i_req.valid) n_state = tlc_pkg::ST_READ;
            end
            tlc_pkg::ST_READ:  n_state = tlc_pkg::ST_LOOK;
            tlc_pkg::ST_LOOK:  n_state = tlc_pkg::ST_WRITE;
            tlc_pkg::ST_WRITE: begin
                if (out_free) n_state = tlc_pkg::ST_IDLE;
            end
            default: n_state = tlc_pkg::ST_CLEAR;
        endcase
        if (ways_wr) n_state = tlc_pkg::ST_CLEAR;
    end

    // State outputs.
    always_comb begin
        i_req.ready = 1'b0;
        clearing    = 1'b0;
        advance     = 1'b0;
        case (r_state)
            tlc_pkg::ST_CLEAR: clearing = 1'b1;
            tlc_pkg::ST_IDLE:  i_req.ready = 1'b1;
            tlc_pkg::ST_WRITE: advance = out_free;
            default: begin
            end
        endcase
    end

    assign i_cfg.ready = 1'b1;

    // Levels above the one that hit are filled; stored rows stay put while we write.
    assign ctl1.clr  = clearing;
    assign ctl2.clr  = clearing;
    assign ctl3.clr  = clearing;
    assign ctl1.fill = advance && !hit1;
    assign ctl2.fill = advance && !hit1 && !hit2;
    assign ctl3.fill = advance && !hit1 && !hit2 && !hit3;

    tlc_level #(.LINES(L1_LINES), .MAX_WAYS(MAX_WAYS), .CW(CW)) u_l1 (
        .i_clk(i_clk), .i_ctl(ctl1), .i_blk(r_blk), .i_wl2(wl2_eff),
        .i_clr_idx(r_clr_cnt), .o_hit(hit1)
    );
    tlc_level #(.LINES(L2_LINES), .MAX_WAYS(MAX_WAYS), .CW(CW)) u_l2 (
        .i_clk(i_clk), .i_ctl(ctl2), .i_blk(r_blk), .i_wl2(wl2_eff),
        .i_clr_idx(r_clr_cnt), .o_hit(hit2)
    );
    tlc_level #(.LINES(L3_LINES), .MAX_WAYS(MAX_WAYS), .CW(CW)) u_l3 (
        .i_clk(i_clk), .i_ctl(ctl3), .i_blk(r_blk), .i_wl2(wl2_eff),
        .i_clr_idx(r_clr_cnt), .o_hit(hit3)
    );

    always_comb begin
        logic [tlc_pkg::NUM_CNT-1:0] bump;
        bump = '0;
        if (hit1) begin
            bump[tlc_pkg::CNT_L1_HIT] = 1'b1;
        end else begin
            bump[tlc_pkg::CNT_L1_MISS] = 1'b1;
            if (hit2) begin
                bump[tlc_pkg::CNT_L2_HIT] = 1'b1;
            end else begin
                bump[tlc_pkg::CNT_L2_MISS] = 1'b1;
                if (hit3) bump[tlc_pkg::CNT_L3_HIT] = 1'b1;
                else      bump[tlc_pkg::CNT_L3_MISS] = 1'b1;
            end
        end
        for (int k = 0; k < tlc_pkg::NUM_CNT; k++) begin
            n_cnt[k] = r_cnt[k];
            if (bump[k] && (r_cnt[k] != '1)) n_cnt[k] = r_cnt[k] + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tlc_pkg::ST_CLEAR;
            r_block_shift <= tlc_pkg::BLOCK_SHIFT_RST;
            r_ways_log2   <= tlc_pkg::WAYS_LOG2_RST;
            r_clr_cnt     <= '0;
            r_out_valid   <= 1'b0;
            for (int k = 0; k < tlc_pkg::NUM_CNT; k++) r_cnt[k] <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr && (i_cfg.index == tlc_pkg::CFG_BLOCK_SHIFT)) begin
                r_block_shift <= i_cfg.data;
            end
            if (ways_wr) begin
                r_ways_log2 <= i_cfg.data[1:0];
                r_clr_cnt   <= '0;
                for (int k = 0; k < tlc_pkg::NUM_CNT; k++) r_cnt[k] <= '0;
            end else begin
                if (clearing) r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_state == tlc_pkg::ST_LOOK) r_cnt <= n_cnt;
            end
            if (advance)            r_out_valid <= 1'b1;
            else if (o_rsp.ready)   r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_xfer) r_blk <= i_req.address >> r_block_shift;
        if (r_state == tlc_pkg::ST_LOOK) begin
            if (hit1)      r_served <= tlc_pkg::SRV_L1;
            else if (hit2) r_served <= tlc_pkg::SRV_L2;
            else if (hit3) r_served <= tlc_pkg::SRV_L3;
            else           r_served <= tlc_pkg::SRV_MEM;
        end
        if (advance) begin
            r_out_served <= r_served;
            r_out_cnt    <= r_cnt;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.served_by     = r_out_served;
    assign o_rsp.first_hits    = r_out_cnt[tlc_pkg::CNT_L1_HIT];
    assign o_rsp.first_misses  = r_out_cnt[tlc_pkg::CNT_L1_MISS];
    assign o_rsp.second_hits   = r_out_cnt[tlc_pkg::CNT_L2_HIT];
    assign o_rsp.second_misses = r_out_cnt[tlc_pkg::CNT_L2_MISS];
    assign o_rsp.third_hits    = r_out_cnt[tlc_pkg::CNT_L3_HIT];
    assign o_rsp.third_misses  = r_out_cnt[tlc_pkg::CNT_L3_MISS];

`ifndef NO_ASSERTIONS
    a_look_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlc_pkg::ST_LOOK) |-> ($past(r_state) == tlc_pkg::ST_READ))
        else $error("lookup stage not preceded by row read");
    a_blk_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlc_pkg::ST_WRITE) |-> $stable(r_blk))
        else $error("block number changed during write-back");
    a_clear_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlc_pkg::ST_CLEAR && r_clr_cnt != '0)
            |-> ($past(r_state) == tlc_pkg::ST_CLEAR))
        else $error("clearing pass entered mid-sweep");
`endif

endmodule
